[design/tensor_axis_permute_defines.svh]
// assertion macros for the tensor axis permute block
`ifndef TENSOR_AXIS_PERMUTE_DEFINES_SVH
`define TENSOR_AXIS_PERMUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define TAP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tap assertion failed");
`define TAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tap assertion failed");
`else
`define TAP_ASSERT_SAME(label, clk, rst, ante, cons)
`define TAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/tap_pkg.sv]
// shared types, register map and helpers for the tensor axis permute block
package tap_pkg;

  localparam int unsigned REG_W  = 9;
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned RIDX_W = 3;

  localparam logic [RIDX_W-1:0] REG_BATCH_COUNT     = 3'd0;
  localparam logic [RIDX_W-1:0] REG_EXTENT_FIRST    = 3'd1;
  localparam logic [RIDX_W-1:0] REG_EXTENT_SECOND   = 3'd2;
  localparam logic [RIDX_W-1:0] REG_EXTENT_THIRD    = 3'd3;
  localparam logic [RIDX_W-1:0] REG_PLACE_OF_FIRST  = 3'd4;
  localparam logic [RIDX_W-1:0] REG_PLACE_OF_SECOND = 3'd5;
  localparam logic [RIDX_W-1:0] REG_PLACE_OF_THIRD  = 3'd6;

  localparam logic [1:0] PLACE_NONE = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] batch_count;
    logic [REG_W-1:0] extent_first;
    logic [REG_W-1:0] extent_second;
    logic [REG_W-1:0] extent_third;
    logic [1:0]       place_of_first;
    logic [1:0]       place_of_second;
    logic [1:0]       place_of_third;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_SETUP_MUL,
    ST_SETUP_ACC,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    STEP_STRIDE,
    STEP_VOLUME,
    STEP_THIRD,
    STEP_SECOND,
    STEP_FIRST,
    STEP_BATCH
  } step_t;

  typedef struct packed {
    logic  mul_en;
    logic  acc_en;
    logic  advance;
    step_t step;
  } cmd_t;

  function automatic logic [REG_W-1:0] clamp_size(logic [REG_W-1:0] v, int unsigned maxv);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (32'(v) > maxv) begin
      r = REG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[design/tap_regs.sv]
// configuration register file with apb-style access
module tap_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tap_pkg::ADDR_W-1:0]    paddr,
  input  logic [tap_pkg::DATA_W-1:0]    pwdata,
  output logic [tap_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output tap_pkg::cfg_t                 cfg,
  output logic                          cfg_wr
);

  logic [tap_pkg::RIDX_W-1:0] ridx;

  assign ridx   = paddr[tap_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_count     <= tap_pkg::REG_W'(1);
      cfg.extent_first    <= tap_pkg::REG_W'(1);
      cfg.extent_second   <= tap_pkg::REG_W'(1);
      cfg.extent_third    <= tap_pkg::REG_W'(1);
      cfg.place_of_first  <= 2'd0;
      cfg.place_of_second <= 2'd1;
      cfg.place_of_third  <= 2'd2;
    end else if (cfg_wr) begin
      case (ridx)
        tap_pkg::REG_BATCH_COUNT:     cfg.batch_count     <= pwdata[tap_pkg::REG_W-1:0];
        tap_pkg::REG_EXTENT_FIRST:    cfg.extent_first    <= pwdata[tap_pkg::REG_W-1:0];
        tap_pkg::REG_EXTENT_SECOND:   cfg.extent_second   <= pwdata[tap_pkg::REG_W-1:0];
        tap_pkg::REG_EXTENT_THIRD:    cfg.extent_third    <= pwdata[tap_pkg::REG_W-1:0];
        tap_pkg::REG_PLACE_OF_FIRST:  cfg.place_of_first  <= pwdata[1:0];
        tap_pkg::REG_PLACE_OF_SECOND: cfg.place_of_second <= pwdata[1:0];
        tap_pkg::REG_PLACE_OF_THIRD:  cfg.place_of_third  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      tap_pkg::REG_BATCH_COUNT:     prdata = tap_pkg::DATA_W'(cfg.batch_count);
      tap_pkg::REG_EXTENT_FIRST:    prdata = tap_pkg::DATA_W'(cfg.extent_first);
      tap_pkg::REG_EXTENT_SECOND:   prdata = tap_pkg::DATA_W'(cfg.extent_second);
      tap_pkg::REG_EXTENT_THIRD:    prdata = tap_pkg::DATA_W'(cfg.extent_third);
      tap_pkg::REG_PLACE_OF_FIRST:  prdata = tap_pkg::DATA_W'(cfg.place_of_first);
      tap_pkg::REG_PLACE_OF_SECOND: prdata = tap_pkg::DATA_W'(cfg.place_of_second);
      tap_pkg::REG_PLACE_OF_THIRD:  prdata = tap_pkg::DATA_W'(cfg.place_of_third);
      default:                      prdata = '0;
    endcase
  end

endmodule

[design/tap_ctrl.sv]
// controller: setup sequencing, input stall and output valid
module tap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr,
  input  logic          in_valid,
  input  logic          out_stall,
  output logic          in_stall,
  output logic          out_valid,
  output tap_pkg::cmd_t cmd
);

  tap_pkg::state_t state, state_next;
  tap_pkg::step_t  step, step_next;
  logic            out_valid_next;
  logic            accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tap_pkg::ST_SETUP_MUL;
      step      <= tap_pkg::STEP_STRIDE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = accept || (out_valid && out_stall);
    if (cfg_wr) begin
      state_next = tap_pkg::ST_SETUP_MUL;
      step_next  = tap_pkg::STEP_STRIDE;
    end else begin
      case (state)
        tap_pkg::ST_SETUP_MUL: state_next = tap_pkg::ST_SETUP_ACC;
        tap_pkg::ST_SETUP_ACC: begin
          if (step == tap_pkg::STEP_BATCH) begin
            state_next = tap_pkg::ST_RUN;
          end else begin
            state_next = tap_pkg::ST_SETUP_MUL;
          end
          case (step)
            tap_pkg::STEP_STRIDE: step_next = tap_pkg::STEP_VOLUME;
            tap_pkg::STEP_VOLUME: step_next = tap_pkg::STEP_THIRD;
            tap_pkg::STEP_THIRD:  step_next = tap_pkg::STEP_SECOND;
            tap_pkg::STEP_SECOND: step_next = tap_pkg::STEP_FIRST;
            tap_pkg::STEP_FIRST:  step_next = tap_pkg::STEP_BATCH;
            default:              step_next = tap_pkg::STEP_STRIDE;
          endcase
        end
        tap_pkg::ST_RUN: state_next = tap_pkg::ST_RUN;
        default:         state_next = tap_pkg::ST_SETUP_MUL;
      endcase
    end
  end

  // outputs
  always_comb begin
    in_stall    = (state != tap_pkg::ST_RUN) || (out_valid && out_stall);
    cmd.mul_en  = (state == tap_pkg::ST_SETUP_MUL);
    cmd.acc_en  = (state == tap_pkg::ST_SETUP_ACC);
    cmd.advance = in_valid && !in_stall;
    cmd.step    = step;
  end

endmodule

[design/tap_dp.sv]
// datapath: position counters, stride setup multiplier and index update
module tap_dp #(
  parameter int unsigned EXTENT_MAX    = 256,
  parameter int unsigned BATCH_MAX     = 256,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tap_pkg::cmd_t                 cmd,
  input  tap_pkg::cfg_t                 cfg,
  input  logic [tap_pkg::DATA_W-1:0]    element_bits,
  output logic [tap_pkg::DATA_W-1:0]    element_out,
  output logic [tap_pkg::IDX_W-1:0]     dest_index,
  output logic                          last_of_tensor,
  output logic                          config_error
);

  localparam int unsigned CW    = $clog2(EXTENT_MAX);
  localparam int unsigned BW    = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
  localparam int unsigned CMP_W = ((CW > tap_pkg::REG_W) ? CW : tap_pkg::REG_W) + 1;
  localparam int unsigned CMPB_W = ((BW > tap_pkg::REG_W) ? BW : tap_pkg::REG_W) + 1;
  localparam int unsigned OUT_W = (ELEMENT_WIDTH < tap_pkg::DATA_W) ? ELEMENT_WIDTH
                                                                     : tap_pkg::DATA_W;
  localparam logic [tap_pkg::DATA_W-1:0] ELEM_MASK =
    tap_pkg::DATA_W'((64'd1 << OUT_W) - 64'd1);

  logic [CW-1:0] pos_first, pos_second, pos_third;
  logic [BW-1:0] batch_pos;

  logic [tap_pkg::REG_W-1:0] ext [3];
  logic [tap_pkg::REG_W-1:0] nb;
  logic [1:0]                place [3];
  logic [tap_pkg::IDX_W-1:0] nd [3];
  logic [tap_pkg::IDX_W-1:0] dstr [3];
  logic [tap_pkg::IDX_W-1:0] s [3];
  logic                      err;
  logic                      w_third, w_second, w_first, w_batch;

  // setup results and running contributions
  logic [tap_pkg::IDX_W-1:0] str0, vol, prod;
  logic [tap_pkg::IDX_W-1:0] c1, c2, p1, cb, idx;
  logic [tap_pkg::IDX_W-1:0] mul_a, mul_b;
  logic [tap_pkg::IDX_W-1:0] mul_full;

  always_comb begin
    ext[0]   = tap_pkg::clamp_size(cfg.extent_first, EXTENT_MAX);
    ext[1]   = tap_pkg::clamp_size(cfg.extent_second, EXTENT_MAX);
    ext[2]   = tap_pkg::clamp_size(cfg.extent_third, EXTENT_MAX);
    nb       = tap_pkg::clamp_size(cfg.batch_count, BATCH_MAX);
    place[0] = cfg.place_of_first;
    place[1] = cfg.place_of_second;
    place[2] = cfg.place_of_third;
    err = (place[0] == tap_pkg::PLACE_NONE) || (place[1] == tap_pkg::PLACE_NONE) ||
          (place[2] == tap_pkg::PLACE_NONE) || (place[0] == place[1]) ||
          (place[0] == place[2]) || (place[1] == place[2]);
    for (int j = 0; j < 3; j++) begin
      nd[j] = tap_pkg::IDX_W'(1);
    end
    for (int k = 0; k < 3; k++) begin
      if (place[k] != tap_pkg::PLACE_NONE) begin
        nd[place[k]] = tap_pkg::IDX_W'(ext[k]);
      end
    end
    dstr[0] = str0;
    dstr[1] = nd[2];
    dstr[2] = tap_pkg::IDX_W'(1);
    for (int k = 0; k < 3; k++) begin
      if (place[k] == tap_pkg::PLACE_NONE) begin
        s[k] = '0;
      end else begin
        s[k] = dstr[place[k]];
      end
    end
  end

  assign w_third  = (CMP_W'(pos_third) + CMP_W'(1)) >= CMP_W'(ext[2]);
  assign w_second = (CMP_W'(pos_second) + CMP_W'(1)) >= CMP_W'(ext[1]);
  assign w_first  = (CMP_W'(pos_first) + CMP_W'(1)) >= CMP_W'(ext[0]);
  assign w_batch  = (CMPB_W'(batch_pos) + CMPB_W'(1)) >= CMPB_W'(nb);

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.step)
      tap_pkg::STEP_STRIDE: begin
        mul_a = nd[1];
        mul_b = nd[2];
      end
      tap_pkg::STEP_VOLUME: begin
        mul_a = nd[0];
        mul_b = str0;
      end
      tap_pkg::STEP_THIRD: begin
        mul_a = tap_pkg::IDX_W'(pos_third);
        mul_b = s[2];
      end
      tap_pkg::STEP_SECOND: begin
        mul_a = tap_pkg::IDX_W'(pos_second);
        mul_b = s[1];
      end
      tap_pkg::STEP_FIRST: begin
        mul_a = tap_pkg::IDX_W'(pos_first);
        mul_b = s[0];
      end
      tap_pkg::STEP_BATCH: begin
        mul_a = tap_pkg::IDX_W'(batch_pos);
        mul_b = vol;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_first  <= '0;
      pos_second <= '0;
      pos_third  <= '0;
      batch_pos  <= '0;
    end else if (cmd.advance) begin
      pos_third <= w_third ? '0 : pos_third + CW'(1);
      if (w_third) begin
        pos_second <= w_second ? '0 : pos_second + CW'(1);
        if (w_second) begin
          pos_first <= w_first ? '0 : pos_first + CW'(1);
          if (w_first) begin
            batch_pos <= w_batch ? '0 : batch_pos + BW'(1);
          end
        end
      end
    end
  end

  // index invariant: idx = cb + pos_first * s0 + p1, p1 = c1 + c2
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_full;
    end
    if (cmd.acc_en) begin
      case (cmd.step)
        tap_pkg::STEP_STRIDE: str0 <= prod;
        tap_pkg::STEP_VOLUME: vol  <= prod;
        tap_pkg::STEP_THIRD: begin
          c2 <= prod;
          p1 <= prod;
        end
        tap_pkg::STEP_SECOND: begin
          c1 <= prod;
          p1 <= p1 + prod;
        end
        tap_pkg::STEP_FIRST: idx <= prod + p1;
        tap_pkg::STEP_BATCH: begin
          cb  <= prod;
          idx <= idx + prod;
        end
        default: ;
      endcase
    end else if (cmd.advance) begin
      if (!w_third) begin
        c2  <= c2 + s[2];
        p1  <= p1 + s[2];
        idx <= idx + s[2];
      end else if (!w_second) begin
        c2  <= '0;
        c1  <= c1 + s[1];
        p1  <= c1 + s[1];
        idx <= idx + s[1] - c2;
      end else if (!w_first) begin
        c2  <= '0;
        c1  <= '0;
        p1  <= '0;
        idx <= idx + s[0] - p1;
      end else if (!w_batch) begin
        c2  <= '0;
        c1  <= '0;
        p1  <= '0;
        cb  <= cb + vol;
        idx <= cb + vol;
      end else begin
        c2  <= '0;
        c1  <= '0;
        p1  <= '0;
        cb  <= '0;
        idx <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      element_out    <= element_bits & ELEM_MASK;
      dest_index     <= err ? '0 : idx;
      last_of_tensor <= w_third && w_second && w_first && w_batch;
      config_error   <= err;
    end
  end

endmodule

[design/tensor_axis_permute.sv]
// top level of the tensor axis permute address generator
//
//   channel  signals                           direction  transfer when
//   in       in_valid in_stall element_bits    to block   in_valid & !in_stall
//   out      out_valid out_stall element_out   from block out_valid & !out_stall
//            dest_index last_of_tensor config_error
//   cfg      psel penable pwrite paddr pwdata  to block   psel & penable & pwrite
//
// one element per cycle while running and no stalled result waits; a result appears the cycle after its transfer
// after reset and after every register write a setup runs: the single shared multiplier
// forms six stride and offset products, each in a multiply state and then an accumulate state
// in_stall stays high during setup, position counters survive register writes
// out_stall holds the output register and stalls the input only while a result waits
`include "tensor_axis_permute_defines.svh"
module tensor_axis_permute #(
  parameter int unsigned EXTENT_MAX    = 256,
  parameter int unsigned BATCH_MAX     = 256,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tap_pkg::ADDR_W-1:0]    paddr,
  input  logic [tap_pkg::DATA_W-1:0]    pwdata,
  output logic [tap_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tap_pkg::DATA_W-1:0]    element_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tap_pkg::DATA_W-1:0]    element_out,
  output logic [tap_pkg::IDX_W-1:0]     dest_index,
  output logic                          last_of_tensor,
  output logic                          config_error
);

  tap_pkg::cfg_t cfg;
  tap_pkg::cmd_t cmd;
  logic          cfg_wr;

  tap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  tap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tap_dp #(
    .EXTENT_MAX    (EXTENT_MAX),
    .BATCH_MAX     (BATCH_MAX),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .element_bits   (element_bits),
    .element_out    (element_out),
    .dest_index     (dest_index),
    .last_of_tensor (last_of_tensor),
    .config_error   (config_error)
  );

  `TAP_ASSERT_NEXT(a_cfg_write_stalls, clk, rst, psel && penable && pwrite, in_stall)
  `TAP_ASSERT_NEXT(a_transfer_gives_result, clk, rst, in_valid && !in_stall, out_valid)
  `TAP_ASSERT_SAME(a_error_zero_index, clk, rst, out_valid && config_error, dest_index == 32'd0)

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the tensor axis permute address generator
module tb;

  localparam int unsigned EXTENT_LIMIT    = 256;
  localparam int unsigned BATCH_LIMIT     = 256;
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned RANDOM_ELEMENTS = 320;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [tap_pkg::DATA_W-1:0] element;
    logic [tap_pkg::IDX_W-1:0]  index;
    logic                       last;
    logic                       error;
  } placed_element_t;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        psel         = 1'b0;
  logic                        penable      = 1'b0;
  logic                        pwrite       = 1'b0;
  logic [tap_pkg::ADDR_W-1:0]  paddr        = '0;
  logic [tap_pkg::DATA_W-1:0]  pwdata       = '0;
  logic [tap_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [tap_pkg::DATA_W-1:0]  element_bits = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic [tap_pkg::DATA_W-1:0]  element_out;
  logic [tap_pkg::IDX_W-1:0]   dest_index;
  logic                        last_of_tensor;
  logic                        config_error;

  tap_pkg::cfg_t      shadow_cfg;
  logic [7:0]         batch_at;
  logic [7:0]         axis_at [3];
  placed_element_t    pending_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        burst_left     = 0;
  int unsigned        stall_left     = 0;
  int unsigned        idle_cycles    = 0;

  tensor_axis_permute u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .element_bits   (element_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .element_out    (element_out),
    .dest_index     (dest_index),
    .last_of_tensor (last_of_tensor),
    .config_error   (config_error)
  );

  always #1 clk = ~clk;

  function automatic int unsigned effective_size(logic [tap_pkg::REG_W-1:0] v,
                                                 int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic placed_element_t predict_placement(logic [tap_pkg::DATA_W-1:0] bits);
    int unsigned     nb;
    int unsigned     ext [3];
    logic [1:0]      place [3];
    longint unsigned dim [3];
    longint unsigned coord [3];
    longint unsigned idx;
    bit              bad;
    bit              carry;
    int              k;
    placed_element_t res;
    nb = effective_size(shadow_cfg.batch_count, BATCH_LIMIT);
    ext[0] = effective_size(shadow_cfg.extent_first, EXTENT_LIMIT);
    ext[1] = effective_size(shadow_cfg.extent_second, EXTENT_LIMIT);
    ext[2] = effective_size(shadow_cfg.extent_third, EXTENT_LIMIT);
    place[0] = shadow_cfg.place_of_first;
    place[1] = shadow_cfg.place_of_second;
    place[2] = shadow_cfg.place_of_third;
    bad = place[0] == tap_pkg::PLACE_NONE || place[1] == tap_pkg::PLACE_NONE ||
          place[2] == tap_pkg::PLACE_NONE ||
          place[0] == place[1] || place[0] == place[2] || place[1] == place[2];
    idx = 0;
    if (!bad) begin
      for (k = 0; k < 3; k++) begin
        dim[place[k]]   = 64'(ext[k]);
        coord[place[k]] = 64'(axis_at[k]);
      end
      idx = coord[0] * dim[1] * dim[2] + coord[1] * dim[2] + coord[2] +
            64'(batch_at) * (64'(ext[0]) * ext[1] * ext[2]);
    end
    res.element = bits;
    res.index   = idx[tap_pkg::IDX_W-1:0];
    res.error   = bad;
    res.last    = (32'(axis_at[2]) + 1 >= ext[2]) && (32'(axis_at[1]) + 1 >= ext[1]) &&
                  (32'(axis_at[0]) + 1 >= ext[0]) && (32'(batch_at) + 1 >= nb);
    // fastest axis first, carry into slower ones and then the batch
    carry = 1'b1;
    for (k = 2; k >= 0; k--) begin
      if (carry) begin
        if (32'(axis_at[k]) + 1 >= ext[k]) begin
          axis_at[k] = '0;
        end else begin
          axis_at[k] = axis_at[k] + 8'd1;
          carry = 1'b0;
        end
      end
    end
    if (carry) begin
      if (32'(batch_at) + 1 >= nb) begin
        batch_at = '0;
      end else begin
        batch_at = batch_at + 8'd1;
      end
    end
    return res;
  endfunction

  task automatic write_register(input logic [tap_pkg::RIDX_W-1:0] which,
                                input logic [tap_pkg::DATA_W-1:0] word);
    if ($urandom_range(0, 3) == 0) begin
      word[tap_pkg::DATA_W-1:tap_pkg::REG_W] = (tap_pkg::DATA_W - tap_pkg::REG_W)'($urandom);
    end
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (which)
      tap_pkg::REG_BATCH_COUNT:     shadow_cfg.batch_count     = word[tap_pkg::REG_W-1:0];
      tap_pkg::REG_EXTENT_FIRST:    shadow_cfg.extent_first    = word[tap_pkg::REG_W-1:0];
      tap_pkg::REG_EXTENT_SECOND:   shadow_cfg.extent_second   = word[tap_pkg::REG_W-1:0];
      tap_pkg::REG_EXTENT_THIRD:    shadow_cfg.extent_third    = word[tap_pkg::REG_W-1:0];
      tap_pkg::REG_PLACE_OF_FIRST:  shadow_cfg.place_of_first  = word[1:0];
      tap_pkg::REG_PLACE_OF_SECOND: shadow_cfg.place_of_second = word[1:0];
      tap_pkg::REG_PLACE_OF_THIRD:  shadow_cfg.place_of_third  = word[1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input int unsigned batches, input int unsigned e1,
                           input int unsigned e2, input int unsigned e3);
    write_register(tap_pkg::REG_BATCH_COUNT, batches);
    write_register(tap_pkg::REG_EXTENT_FIRST, e1);
    write_register(tap_pkg::REG_EXTENT_SECOND, e2);
    write_register(tap_pkg::REG_EXTENT_THIRD, e3);
  endtask

  task automatic set_places(input logic [1:0] p1, input logic [1:0] p2, input logic [1:0] p3);
    write_register(tap_pkg::REG_PLACE_OF_FIRST, tap_pkg::DATA_W'(p1));
    write_register(tap_pkg::REG_PLACE_OF_SECOND, tap_pkg::DATA_W'(p2));
    write_register(tap_pkg::REG_PLACE_OF_THIRD, tap_pkg::DATA_W'(p3));
  endtask

  task automatic set_random_permutation();
    logic [1:0] p0;
    logic [1:0] p1;
    p0 = 2'($urandom_range(0, 2));
    p1 = 2'((p0 + $urandom_range(1, 2)) % 3);
    set_places(p0, p1, 2'(3 - p0 - p1));
  endtask

  // one transfer on the input channel, bursts and gaps chosen here
  task automatic send_element(input logic [tap_pkg::DATA_W-1:0] bits);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     = 1'b1;
    element_bits = bits;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_placement(bits));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_defaults();
    send_element('0);
    send_element({tap_pkg::DATA_W{1'b1}});
    send_element(32'hAAAA_5555);
    send_element(32'h8000_0001);
    drain_results();
  endtask

  task automatic test_transpose();
    set_shape(1, 1, 2, 3);
    set_places(0, 2, 1);
    repeat (6) send_element($urandom);
    drain_results();
  endtask

  // nhwc to nchw, then nchw to nhwc half way through the same tensor
  task automatic test_layout_change();
    set_shape(1, 2, 2, 2);
    set_places(1, 2, 0);
    repeat (4) send_element($urandom);
    drain_results();
    set_places(2, 0, 1);
    repeat (4) send_element($urandom);
    drain_results();
  endtask

  task automatic test_bad_placement();
    set_places(tap_pkg::PLACE_NONE, 1, 2);
    repeat (2) send_element($urandom);
    drain_results();
    set_places(1, 1, 0);
    repeat (2) send_element($urandom);
    drain_results();
  endtask

  task automatic test_mid_tensor_resize();
    set_shape(1, 1, 1, 4);
    set_places(0, 1, 2);
    repeat (3) send_element($urandom);
    drain_results();
    write_register(tap_pkg::REG_EXTENT_THIRD, 2);
    repeat (3) send_element($urandom);
    drain_results();
  endtask

  // zero sizes count as one, oversize ones saturate
  task automatic test_size_extremes();
    set_shape(0, 256, 0, 0);
    set_random_permutation();
    repeat (256) send_element($urandom);
    drain_results();
    set_shape(1, 1, 1, 511);
    repeat (20) send_element($urandom);
    drain_results();
    set_shape(511, 1, 1, 1);
    repeat (20) send_element($urandom);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned     sent;
    int unsigned     count;
    int unsigned     r;
    int unsigned     size;
    longint unsigned volume;
    sent = 0;
    while (sent < RANDOM_ELEMENTS) begin
      for (r = 0; r < 4; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          size = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 511) : $urandom_range(0, 3);
          write_register(tap_pkg::RIDX_W'(tap_pkg::REG_BATCH_COUNT + r), size);
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 3) != 0) begin
          set_random_permutation();
        end else begin
          set_places(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
        end
      end
      volume = 64'(effective_size(shadow_cfg.batch_count, BATCH_LIMIT)) *
               effective_size(shadow_cfg.extent_first, EXTENT_LIMIT) *
               effective_size(shadow_cfg.extent_second, EXTENT_LIMIT) *
               effective_size(shadow_cfg.extent_third, EXTENT_LIMIT);
      if (volume > 120) begin
        count = $urandom_range(1, 120);
      end else if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, 32'(volume));
      end else begin
        count = 32'(volume);
      end
      repeat (count) begin
        if ($urandom_range(0, 7) == 0) begin
          send_element($urandom_range(0, 1) ? {tap_pkg::DATA_W{1'b1}}
                                            : {tap_pkg::DATA_W{1'b0}});
        end else begin
          send_element($urandom);
        end
      end
      sent += count;
      drain_results();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      out_stall  = !out_stall && ($urandom_range(0, 2) == 0);
      stall_left = out_stall ? $urandom_range(0, 7) : $urandom_range(0, 29);
    end
  end

  always @(posedge clk) begin : check_results
    placed_element_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected transfer: element %h index %0d last %b error %b",
                   element_out, dest_index, last_of_tensor, config_error);
        end
      end else begin
        want = pending_q.pop_front();
        if (element_out !== want.element || dest_index !== want.index ||
            last_of_tensor !== want.last || config_error !== want.error) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: element %h/%h index %0d/%0d last %b/%b error %b/%b",
                     want.element, element_out, want.index, dest_index,
                     want.last, last_of_tensor, want.error, config_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** tensor_axis_permute: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    shadow_cfg = '{batch_count: 9'd1, extent_first: 9'd1, extent_second: 9'd1,
                   extent_third: 9'd1, place_of_first: 2'd0, place_of_second: 2'd1,
                   place_of_third: 2'd2};
    batch_at = '0;
    axis_at  = '{default: '0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_transpose();
    test_layout_change();
    test_bad_placement();
    test_mid_tensor_resize();
    test_size_extremes();
    test_random();
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** tensor_axis_permute: PASSED **");
    end else begin
      $display("** tensor_axis_permute: FAILED **");
    end
    $finish;
  end

endmodule
